@@ design/mft_pkg.sv @@
`default_nettype none
package mft_pkg;

  // Identifier window of the feedback frames.
  localparam logic [10:0] ID_FIRST = 11'h201;
  localparam logic [10:0] ID_LAST  = 11'h208;

  // Encoder geometry: 8192 counts per turn, turn steps on jumps beyond half of that.
  localparam int             TURN_SHIFT = 13;
  localparam logic signed [16:0] HALF_TURN = 17'sd4096;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENABLED          = 2'd0;
  localparam logic [1:0] CFG_ANGLE_DEADBAND   = 2'd1;
  localparam logic [1:0] CFG_CURRENT_DEADBAND = 2'd2;

  localparam logic [11:0] ANGLE_DEADBAND_RST   = 12'd100;
  localparam logic [14:0] CURRENT_DEADBAND_RST = 15'd200;

  // Per-motor tracking entry kept in the table memory.
  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] prev_angle;
    logic [15:0] turns;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

@@ design/mft_ram.sv @@
`default_nettype none
module mft_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

@@ design/motor_feedback_turn_tracker.sv @@
`default_nettype none
// Multi-turn tracker for motor feedback frames.
// Input stream: one beat per received frame. in_tuser carries the bus number,
// in_tdata the identifier and the payload fields. A new frame is not taken
// before the last one is through: in the accept cycle the motor's entry is read
// from the table memory (synchronous read), then in the compute state the turn
// step and the total angle are computed, the entry is written back and the
// output register is loaded with the result beat.
// A frame that is dropped (block disabled, foreign identifier, unused bus)
// is taken while idle, leaves the block idle and produces no beat.
// Output stream: one beat per frame that was processed, held in an output
// register until out_tready. While that register is full and not taken, the
// block waits in its compute cycle and in_tready stays low.
// Configuration: cfg_valid/cfg_index/cfg_data, always ready, written only while
// the block is idle, a rule for the user that the block does not enforce. Reset
// clears the state, the first-seen bits and restores the register defaults
// (disabled, deadbands 100 and 200); the table needs no clearing: unseen entries go unused.
module motor_feedback_turn_tracker #(
  parameter int MOTORS_PER_BUS = 8,
  parameter int BUS_COUNT      = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,  // frame_id[10:0], angle_raw[26:11], speed_raw[42:27],
                                      // current_raw[58:43], temperature_raw[66:59], zero fill
  input  wire logic        in_tuser,  // bus
  // Output stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata, // motor_slot[2:0], multi_turn_angle[32:3], speed[48:33],
                                      // current[64:49], temperature[72:65], zero fill
  output logic             out_tuser  // out_bus
);
  import mft_pkg::*;

  localparam int DEPTH = MOTORS_PER_BUS * BUS_COUNT;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CALC = 1'b1;

  // Configuration registers.
  logic        enabled_r;
  logic [11:0] angle_db_r;
  logic [14:0] current_db_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      angle_db_r   <= ANGLE_DEADBAND_RST;
      current_db_r <= CURRENT_DEADBAND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLED:          enabled_r    <= cfg_data[0];
        CFG_ANGLE_DEADBAND:   angle_db_r   <= cfg_data[11:0];
        CFG_CURRENT_DEADBAND: current_db_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input decode.
  logic [10:0] in_id;
  logic [2:0]  in_slot;
  logic [31:0] in_idx_wide;
  logic [IDX_W-1:0] in_idx;
  logic        in_fire;
  logic        in_ok;

  assign in_id       = in_tdata[10:0];
  assign in_slot     = 3'(in_id - ID_FIRST);
  assign in_idx_wide = 32'(in_tuser) * 32'(MOTORS_PER_BUS) + 32'(in_slot);
  assign in_idx      = in_idx_wide[IDX_W-1:0];
  assign in_fire     = in_tvalid && in_tready;
  assign in_ok       = enabled_r && (in_id >= ID_FIRST) && (in_id <= ID_LAST)
                       && (32'(in_slot) < 32'(MOTORS_PER_BUS))
                       && (32'(in_tuser) < 32'(BUS_COUNT));

  logic             state_r, state_nxt;
  logic             bus_r;
  logic [2:0]       slot_r;
  logic [IDX_W-1:0] idx_r;
  logic [15:0]      angle_r;
  logic [15:0]      speed_r;
  logic [15:0]      current_r;
  logic [7:0]       temp_r;
  logic [DEPTH-1:0] seen_r;

  logic             out_tvalid_r;
  logic [79:0]      out_tdata_r;
  logic             out_tuser_r;

  logic   out_free;
  logic   mem_we;
  entry_t mem_rdata;
  entry_t cur_entry;
  entry_t new_entry;
  logic [IDX_W-1:0] rd_addr;

  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign mem_we    = (state_r == S_CALC) && out_free;
  assign rd_addr   = (state_r == S_IDLE) ? in_idx : idx_r;

  mft_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(idx_r),
    .wdata(new_entry),
    .raddr(rd_addr),
    .rdata(mem_rdata)
  );

  // An entry never seen reads as a fresh one: offset and previous angle take
  // this frame's angle and the turn count starts from zero.
  always_comb begin
    if (seen_r[idx_r]) begin
      cur_entry = mem_rdata;
    end else begin
      cur_entry = '{offset: angle_r, prev_angle: angle_r, turns: 16'd0};
    end
  end

  logic signed [16:0] diff;
  logic [15:0]        turns_nxt;
  logic signed [29:0] scaled;
  logic signed [16:0] delta;
  logic signed [29:0] total;
  logic signed [29:0] adb;
  logic signed [29:0] total_out;
  logic signed [16:0] cur_s;
  logic signed [16:0] cdb;
  logic [15:0]        current_out;

  always_comb begin
    diff = $signed({1'b0, angle_r}) - $signed({1'b0, cur_entry.prev_angle});
    if (diff < -HALF_TURN) begin
      turns_nxt = cur_entry.turns + 16'd1;
    end else if (diff > HALF_TURN) begin
      turns_nxt = cur_entry.turns - 16'd1;
    end else begin
      turns_nxt = cur_entry.turns;
    end
    scaled = $signed({turns_nxt[15], turns_nxt, 13'd0});
    delta  = $signed({1'b0, angle_r}) - $signed({1'b0, cur_entry.offset});
    total  = scaled + 30'(delta);
    adb    = $signed({18'd0, angle_db_r});
    if (total >= -adb && total <= adb) begin
      total_out = '0;
    end else begin
      total_out = total;
    end
    cur_s = $signed({current_r[15], current_r});
    cdb   = $signed({2'd0, current_db_r});
    if (cur_s >= -cdb && cur_s <= cdb) begin
      current_out = '0;
    end else begin
      current_out = current_r;
    end
    new_entry = '{offset: cur_entry.offset, prev_angle: angle_r, turns: turns_nxt};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_ok) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      seen_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        seen_r[idx_r] <= 1'b1;
        out_tvalid_r  <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bus_r     <= in_tuser;
      slot_r    <= in_slot;
      idx_r     <= in_idx;
      angle_r   <= in_tdata[26:11];
      speed_r   <= in_tdata[42:27];
      current_r <= in_tdata[58:43];
      temp_r    <= in_tdata[66:59];
    end
    if (mem_we) begin
      out_tuser_r <= bus_r;
      out_tdata_r <= {7'd0, temp_r, current_out, speed_r, total_out, slot_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // A processed frame always moves on to the compute cycle.
  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ok) |=> (state_r == S_CALC))
    else $error("accepted frame did not enter the compute cycle");

  // A dropped frame never produces an output beat.
  a_drop_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ok) |=> (state_r == S_IDLE))
    else $error("dropped frame started processing");

  // Output beats only appear after a compute cycle.
  a_beat_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_CALC))
    else $error("output beat without a compute cycle");

  // After a write-back the motor's entry is marked seen.
  a_seen_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> seen_r[idx_r])
    else $error("entry not marked seen after write-back");

endmodule
`default_nettype wire
